// ----- design/tbsg_pkg.sv -----
package tbsg_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_SAMPLE_RATE    = 3'd0,
    REG_START_SAMPLE   = 3'd1,
    REG_BURST_SAMPLES  = 3'd2,
    REG_ENVELOPE_SLOPE = 3'd3,
    REG_AMPLITUDE      = 3'd4,
    REG_PHASE_STEP     = 3'd5,
    REG_SAMPLE_COUNT   = 3'd6
  } cfg_reg_t;

  // latest valid burst start, in seconds
  localparam int START_MAX_SECONDS = 499;

  // envelope gain handed from the envelope pipe to the datapath
  typedef struct packed {
    logic        on;
    logic        full;
    logic [31:0] lo;
  } env_t;

  // one finished result
  typedef struct packed {
    logic               start_invalid;
    logic               last;
    logic signed [15:0] sample;
  } result_t;

endpackage

// ----- design/tone_burst_sample_generator_top.sv -----
// Tone burst sample generator: each sample index on the input stream gives one signed
// q3.12 sample of a sine burst with a linear fade in and out over the first and last
// twentieth of the burst, zero outside it and zero with the error flag in tuser when
// the start lies before 1 s or after 499 s. One index is taken every clock while input
// ready is high. The datapath is a 7-stage pipeline (phase multiply, table address,
// registered sine table read, envelope and amplitude multiplies, rounding) ending in
// an output register with a skid entry, so input ready drops only while that skid
// entry is full. Configuration is written through cfg_we/cfg_index/cfg_data; the user
// must write only while no transaction is in flight; the block does not enforce it.
module tone_burst_sample_generator_top
  import tbsg_pkg::*;
#(
  parameter int SINE_TABLE_BITS = 10,
  parameter int INDEX_BITS      = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // sample_index[23:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // sample[15:0]
  output logic        m_axis_tlast,
  output logic        m_axis_tuser    // start_invalid
);

  localparam int          SB       = SINE_TABLE_BITS;
  localparam logic [23:0] IDX_MASK = (INDEX_BITS >= 24) ? 24'hFFFFFF
                                     : 24'((64'd1 << INDEX_BITS) - 64'd1);
  localparam logic [SB:0] TAB_N    = (SB + 1)'(1) << SB;

  // configuration registers
  logic [15:0] sample_rate;
  logic [23:0] start_sample;
  logic [23:0] burst_samples;
  logic [31:0] envelope_slope;
  logic [14:0] amplitude;
  logic [31:0] phase_step;
  logic [24:0] sample_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_rate    <= 16'd100;
      start_sample   <= 24'd1000;
      burst_samples  <= 24'd20000;
      envelope_slope <= 32'd85899346;
      amplitude      <= 15'd10240;
      phase_step     <= 32'd214748365;
      sample_count   <= 25'd50001;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SAMPLE_RATE:    sample_rate    <= cfg_data[15:0];
        REG_START_SAMPLE:   start_sample   <= cfg_data[23:0];
        REG_BURST_SAMPLES:  burst_samples  <= cfg_data[23:0];
        REG_ENVELOPE_SLOPE: envelope_slope <= cfg_data;
        REG_AMPLITUDE:      amplitude      <= cfg_data[14:0];
        REG_PHASE_STEP:     phase_step     <= cfg_data;
        REG_SAMPLE_COUNT:   sample_count   <= cfg_data[24:0];
        default: ;
      endcase
    end
  end

  // pipeline advance, held while the skid entry is occupied
  logic          en;
  logic [7:1]    v;
  logic [6:1]    last_p;
  logic [6:1]    inv_p;
  logic [6:3]    neg_p;
  logic [23:0]   n1;
  logic [31:0]   ph2;
  logic [55:0]   ph_full;
  logic [SB:0]   addr3;
  logic [SB-1:0] a2;
  logic [16:0]   smag4;
  logic [31:0]   sa5;
  env_t          env5;
  logic [63:0]   prod6;
  logic          on6;
  logic [64:0]   rsum;
  logic [16:0]   mag;
  logic [15:0]   sat;
  result_t       res7;
  logic          skid_ready;
  result_t       out_res;
  logic [24:0]   max_start;
  logic          invalid;

  assign en            = skid_ready;
  assign s_axis_tready = en;

  // start window check, last flag
  assign max_start = 25'(sample_rate) * 25'(START_MAX_SECONDS);
  assign invalid   = (start_sample < {8'd0, sample_rate}) || ({1'b0, start_sample} > max_start);

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[6:1], s_axis_tvalid};
    end
  end

  // stage 1: index capture and flags
  always_ff @(posedge clk) begin
    if (en) begin
      n1        <= s_axis_tdata & IDX_MASK;
      last_p[1] <= ({1'b0, s_axis_tdata & IDX_MASK} + 25'd1) == sample_count;
      inv_p[1]  <= invalid;
      last_p[6:2] <= last_p[5:1];
      inv_p[6:2]  <= inv_p[5:1];
    end
  end

  // stage 2: phase accumulation as index times tuning word
  assign ph_full = n1 * phase_step;

  always_ff @(posedge clk) begin
    if (en) begin
      ph2 <= ph_full[31:0];
    end
  end

  // stage 3: quarter-wave address and sign
  assign a2 = ph2[29 -: SB];

  always_ff @(posedge clk) begin
    if (en) begin
      addr3     <= ph2[30] ? TAB_N - {1'b0, a2} : {1'b0, a2};
      neg_p[3]  <= ph2[31];
      neg_p[6:4] <= neg_p[5:3];
    end
  end

  // stage 4: sine magnitude
  tbsg_sine_rom #(.SINE_TABLE_BITS(SB)) u_rom (
    .clk  (clk),
    .en   (en),
    .addr (addr3),
    .data (smag4)
  );

  // stages 2 to 5: envelope gain
  tbsg_envelope u_env (
    .clk            (clk),
    .en             (en),
    .n              (n1),
    .start_sample   (start_sample),
    .burst_samples  (burst_samples),
    .envelope_slope (envelope_slope),
    .env            (env5)
  );

  // stage 5: sine times amplitude
  always_ff @(posedge clk) begin
    if (en) begin
      sa5 <= smag4 * amplitude;
    end
  end

  // stage 6: apply gain, unity gain is a plain shift
  always_ff @(posedge clk) begin
    if (en) begin
      prod6 <= env5.full ? {sa5, 32'd0} : sa5 * env5.lo;
      on6   <= env5.on;
    end
  end

  // stage 7: round half away from zero, sign and saturate
  assign rsum = {1'b0, prod6} + (65'd1 << 47);
  assign mag  = rsum[64:48];

  always_comb begin
    if (neg_p[6]) begin
      sat = (mag > 17'd32768) ? 16'h8000 : 16'(17'd0 - mag);
    end else begin
      sat = (mag > 17'd32767) ? 16'h7FFF : mag[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res7.sample        <= (on6 && !inv_p[6]) ? signed'(sat) : 16'sd0;
      res7.last          <= last_p[6];
      res7.start_invalid <= inv_p[6];
    end
  end

  // output register and skid entry
  tbsg_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v[7]),
    .in_ready  (skid_ready),
    .in_data   (res7),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (out_res)
  );

  assign m_axis_tdata = out_res.sample;
  assign m_axis_tlast = out_res.last;
  assign m_axis_tuser = out_res.start_invalid;

endmodule

// ----- design/tbsg_sine_rom.sv -----
module tbsg_sine_rom
  import tbsg_pkg::*;
#(
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic [SINE_TABLE_BITS:0] addr,
  output logic [16:0]              data
);

  localparam int TAB_N = 1 << SINE_TABLE_BITS;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] TAYLOR_DIV [1:10] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272, 64'd342, 64'd420
  };

  typedef logic [16:0] tab_t [0:TAB_N];

  // quarter-wave sine in q1.16, from a q30 taylor series at elaboration
  function automatic tab_t build_tab();
    tab_t               t;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        r;
    for (int k = 0; k <= TAB_N; k++) begin
      x    = (64'(k) * HALF_PI_Q30) >> SINE_TABLE_BITS;
      x2   = (x * x) >> 30;
      term = x;
      sum  = signed'(x);
      for (int i = 1; i <= 10; i++) begin
        term = ((term * x2) >> 30) / TAYLOR_DIV[i];
        if (i % 2 == 1) begin
          sum = sum - signed'(term);
        end else begin
          sum = sum + signed'(term);
        end
      end
      if (sum < 0) begin
        sum = 64'sd0;
      end
      r = (unsigned'(sum) + 64'd8192) >> 14;
      if (r > 64'd65536) begin
        r = 64'd65536;
      end
      t[k] = r[16:0];
    end
    return t;
  endfunction

  localparam tab_t SINE_TAB = build_tab();

  // registered table read
  always_ff @(posedge clk) begin
    if (en) begin
      data <= SINE_TAB[addr];
    end
  end

endmodule

// ----- design/tbsg_envelope.sv -----
module tbsg_envelope
  import tbsg_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic [23:0] n,
  input  logic [23:0] start_sample,
  input  logic [23:0] burst_samples,
  input  logic [31:0] envelope_slope,
  output env_t        env
);

  logic [24:0] diff;
  logic [23:0] d2;
  logic        ge2;
  logic [28:0] d20;
  logic [28:0] b1;
  logic [28:0] b19;
  logic        up;
  logic        hold;
  logic        down;
  logic [23:0] f3;
  logic        on3;
  logic        hold3;
  logic [55:0] gp4;
  logic        on4;
  logic        hold4;

  assign diff = {1'b0, n} - {1'b0, start_sample};

  // offset into the burst
  always_ff @(posedge clk) begin
    if (en) begin
      d2  <= diff[23:0];
      ge2 <= !diff[24];
    end
  end

  // region of the fade: ramp up, hold, ramp down
  assign d20  = {1'b0, d2, 4'b0} + {3'b0, d2, 2'b0};
  assign b1   = {5'b0, burst_samples};
  assign b19  = {1'b0, burst_samples, 4'b0} + {4'b0, burst_samples, 1'b0} + b1;
  assign up   = d20 < b1;
  assign hold = d20 < b19;
  assign down = d2 < burst_samples;

  always_ff @(posedge clk) begin
    if (en) begin
      f3    <= up ? d2 : burst_samples - d2;
      on3   <= ge2 && (up || hold || down);
      hold3 <= !up && hold;
    end
  end

  // fade distance times slope
  always_ff @(posedge clk) begin
    if (en) begin
      gp4   <= f3 * envelope_slope;
      on4   <= on3;
      hold4 <= hold3;
    end
  end

  // saturate at unity gain
  always_ff @(posedge clk) begin
    if (en) begin
      env.on   <= on4;
      env.full <= hold4 || (gp4[55:32] != 24'd0);
      env.lo   <= gp4[31:0];
    end
  end

endmodule

// ----- design/tbsg_skid.sv -----
module tbsg_skid
  import tbsg_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  result_t in_data,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  logic    sk_valid;
  result_t sk_data;
  logic    take;

  assign take     = out_ready || !out_valid;
  assign in_ready = !sk_valid;

  // output register backed by one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sk_valid  <= 1'b0;
    end else if (sk_valid) begin
      if (take) begin
        out_data  <= sk_data;
        out_valid <= 1'b1;
        sk_valid  <= 1'b0;
      end
    end else if (in_valid) begin
      if (take) begin
        out_data  <= in_data;
        out_valid <= 1'b1;
      end else begin
        sk_data  <= in_data;
        sk_valid <= 1'b1;
      end
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ----- design/tbsg_checker.sv -----
module tbsg_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // no result right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // an invalid start always yields a zero sample
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 16'd0)
    else $error("nonzero sample with invalid start");

  // input backpressure only while a result waits at the output
  a_ready_skid: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with empty output");

endmodule

bind tone_burst_sample_generator_top tbsg_checker u_tbsg_checker (.*);

// ----- test/tone_burst_sample_generator_top_tb.sv -----
module tone_burst_sample_generator_top_tb;
  import tbsg_pkg::*;

  typedef longint unsigned u64_t;

  localparam int TAB_BITS = 10;
  localparam int TAB_N = 1 << TAB_BITS;
  localparam int LATENCY = 8;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int RANDOM_CONFIGS = 32;
  localparam int ITEMS_PER_CONFIG = 60;
  localparam int MAX_REPORTS = 100;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned ONE_Q32 = 64'd1 << 32;

  // register image kept by the testbench
  typedef struct {
    logic [15:0] rate;
    logic [23:0] start;
    logic [23:0] burst;
    logic [31:0] slope;
    logic [14:0] amp;
    logic [31:0] step;
    logic [24:0] count;
  } burst_cfg_t;

  // one expected sample with the index that caused it
  typedef struct {
    logic [23:0] idx;
    result_t     res;
  } pending_sample_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  cfg_reg_t    cfg_index = REG_SAMPLE_RATE;
  logic [31:0] cfg_data = '0;
  logic        s_valid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_data = '0;
  logic        m_axis_tvalid;
  logic        m_ready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tuser;

  burst_cfg_t       cur;
  longint unsigned  sine_rom [0:TAB_N];
  pending_sample_t  expected_samples[$];
  bit               tx_no_idle = 1'b0;
  bit               rx_no_idle = 1'b0;
  logic             rx_hold_off = 1'b0;
  event             hold_off_start;
  int               mismatches = 0;
  int               reports = 0;
  int               items_sent = 0;
  int               results_checked = 0;
  int               configs_loaded = 0;

  tone_burst_sample_generator_top u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_data),        // sample_index[23:0]
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_axis_tdata),  // sample[15:0]
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)   // start_invalid
  );

  // clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // quarter-wave magnitude, q1.16, from a q30 taylor series
  function automatic longint unsigned sine_mag_q16(input int k);
    longint unsigned x, x2, term, r;
    longint sum;
    x = (u64_t'(k) * HALF_PI_Q30) >> TAB_BITS;
    x2 = (x * x) >> 30;
    term = x;
    sum = longint'(x);
    for (int i = 1; i <= 10; i++) begin
      term = ((term * x2) >> 30) / (u64_t'(2 * i) * u64_t'(2 * i + 1));
      if (i % 2 == 1) sum -= longint'(term);
      else sum += longint'(term);
    end
    if (sum < 0) sum = 0;
    r = (u64_t'(sum) + 64'd8192) >> 14;
    if (r > 64'd65536) r = 64'd65536;
    return r;
  endfunction

  // expected sample, flags included, for one index under the current registers
  function automatic pending_sample_t burst_sample_of(input logic [23:0] idx);
    pending_sample_t p;
    longint unsigned n, d, b, g, smag, mag, prod;
    logic [31:0] ph;
    logic [1:0] quad;
    int unsigned addr;
    bit invalid_start, in_burst;
    n = idx;
    g = 0;
    in_burst = 1'b1;
    p.idx = idx;
    p.res.last = (n + 1 == u64_t'(cur.count));
    invalid_start = (cur.start < cur.rate) ||
                    (u64_t'(cur.start) >
                     u64_t'(START_MAX_SECONDS) * u64_t'(cur.rate));
    p.res.start_invalid = invalid_start;
    p.res.sample = '0;
    if (!invalid_start && n >= cur.start) begin
      d = n - cur.start;
      b = cur.burst;
      // envelope: ramp up, hold, ramp down, off
      if (20 * d < b) g = d * cur.slope;
      else if (20 * d < 19 * b) g = ONE_Q32;
      else if (d < b) g = (b - d) * cur.slope;
      else in_burst = 1'b0;
      if (g > ONE_Q32) g = ONE_Q32;
      if (in_burst) begin
        prod = n * u64_t'(cur.step);
        ph = 32'(prod);
        quad = ph[31:30];
        addr = (ph >> (30 - TAB_BITS)) & (TAB_N - 1);
        smag = quad[0] ? sine_rom[TAB_N - addr] : sine_rom[addr];
        mag = (smag * u64_t'(cur.amp) * g + (64'd1 << 47)) >> 48;
        if (quad[1]) begin
          if (mag > 64'd32768) mag = 64'd32768;
          p.res.sample = 16'(64'd0 - mag);
        end else begin
          if (mag > 64'd32767) mag = 64'd32767;
          p.res.sample = 16'(mag);
        end
      end
    end
    return p;
  endfunction

  function automatic burst_cfg_t make_config(input logic [15:0] rate, input logic [23:0] start,
                                             input logic [23:0] burst, input logic [31:0] slope,
                                             input logic [14:0] amp, input logic [31:0] step,
                                             input logic [24:0] count);
    burst_cfg_t c;
    c.rate = rate;
    c.start = start;
    c.burst = burst;
    c.slope = slope;
    c.amp = amp;
    c.step = step;
    c.count = count;
    return c;
  endfunction

  // nominal slope is 20 / burst in q0.32
  function automatic logic [31:0] nominal_slope(input logic [23:0] burst);
    longint unsigned s;
    if (burst == 0) return '1;
    s = (64'd20 << 32) / burst;
    if (s > 64'hFFFF_FFFF) s = 64'hFFFF_FFFF;
    return 32'(s);
  endfunction

  // mostly valid starts and small bursts, with full random values mixed in
  function automatic burst_cfg_t random_config();
    burst_cfg_t c;
    int unsigned kmax, r;
    c.rate = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 2000));
    if (c.rate == 0) begin
      c.start = '0;
    end else if ($urandom_range(0, 5) == 0) begin
      c.start = 24'($urandom);
    end else begin
      kmax = 24'hFF_FFFF / c.rate;
      if (kmax > START_MAX_SECONDS) kmax = START_MAX_SECONDS;
      c.start = 24'(c.rate * $urandom_range(1, kmax));
    end
    r = $urandom_range(0, 9);
    if (r < 6) c.burst = 24'($urandom_range(1, 400));
    else if (r < 9) c.burst = 24'($urandom);
    else c.burst = 24'($urandom_range(1, 19));
    c.slope = ($urandom_range(0, 4) == 0) ? 32'($urandom) : nominal_slope(c.burst);
    c.amp = 15'($urandom);
    c.step = 32'($urandom);
    r = $urandom_range(0, 9);
    if (r < 6) c.count = 25'(c.start + c.burst + $urandom_range(0, 50));
    else if (r < 9) c.count = 25'($urandom);
    else c.count = ($urandom_range(0, 1) == 0) ? 25'd0 : 25'd16777216;
    return c;
  endfunction

  // index aimed at the envelope corners, the last index or anywhere
  function automatic logic [23:0] pick_index();
    longint d, b;
    int unsigned r;
    b = cur.burst;
    r = $urandom_range(0, 9);
    case (r)
      0, 1, 2, 3: d = $urandom_range(0, 32'(b + 20));
      4:          d = b / 20 + $urandom_range(0, 6) - 3;
      5:          d = (19 * b) / 20 + $urandom_range(0, 6) - 3;
      6:          d = b + $urandom_range(0, 6) - 3;
      7:          return 24'(cur.count - 1 + $urandom_range(0, 1));
      default:    return 24'($urandom);
    endcase
    if (d < 0) d = 0;
    return 24'(cur.start + d);
  endfunction

  // write all seven registers back to back, block idle
  task automatic load_config(input burst_cfg_t c);
    cfg_we <= 1'b1;
    cfg_index <= REG_SAMPLE_RATE;
    cfg_data <= 32'(c.rate);
    @(posedge clk);
    cfg_index <= REG_START_SAMPLE;
    cfg_data <= 32'(c.start);
    @(posedge clk);
    cfg_index <= REG_BURST_SAMPLES;
    cfg_data <= 32'(c.burst);
    @(posedge clk);
    cfg_index <= REG_ENVELOPE_SLOPE;
    cfg_data <= c.slope;
    @(posedge clk);
    cfg_index <= REG_AMPLITUDE;
    cfg_data <= 32'(c.amp);
    @(posedge clk);
    cfg_index <= REG_PHASE_STEP;
    cfg_data <= c.step;
    @(posedge clk);
    cfg_index <= REG_SAMPLE_COUNT;
    cfg_data <= 32'(c.count);
    @(posedge clk);
    cfg_we <= 1'b0;
    cur = c;
    configs_loaded++;
  endtask

  // one input transaction, with a random gap ahead of it
  task automatic send_index(input logic [23:0] idx);
    int gap;
    gap = tx_no_idle ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_valid <= 1'b1;
    s_data <= idx;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    expected_samples.push_back(burst_sample_of(idx));
    items_sent++;
  endtask

  // stop offering and wait until every expected sample is back
  task automatic wait_idle();
    s_valid <= 1'b0;
    @(posedge clk);
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic test_reset_defaults();
    logic [23:0] idx [12] = '{24'd0, 24'd999, 24'd1000, 24'd1001, 24'd1999, 24'd2000,
                              24'd10500, 24'd20000, 24'd20999, 24'd21000, 24'd50000,
                              24'hFF_FFFF};
    cur = make_config(16'd100, 24'd1000, 24'd20000, 32'd85899346, 15'd10240,
                      32'd214748365, 25'd50001);
    foreach (idx[i]) send_index(idx[i]);
    wait_idle();
  endtask

  task automatic test_special_cases();
    // saturation at full amplitude and full gain, quadrant peaks, zero sample_count
    load_config(make_config(16'd100, 24'd100, 24'd1000, 32'hFFFF_FFFF, 15'h7FFF,
                            32'h4000_0000, 25'd0));
    send_index(24'd101);
    send_index(24'd103);
    send_index(24'd600);
    send_index(24'd1099);
    send_index(24'hFF_FFFF);
    wait_idle();
    // start before 1 s
    load_config(make_config(16'd100, 24'd99, 24'd1000, 32'd85899346, 15'd4096,
                            32'd123456789, 25'd100));
    send_index(24'd99);
    send_index(24'd500);
    wait_idle();
    // start right at 499 s, then one sample later
    load_config(make_config(16'd2, 24'd998, 24'd100, nominal_slope(24'd100), 15'd4096,
                            32'd33554432, 25'd999));
    send_index(24'd998);
    wait_idle();
    load_config(make_config(16'd2, 24'd999, 24'd100, nominal_slope(24'd100), 15'd4096,
                            32'd33554432, 25'd999));
    send_index(24'd1000);
    wait_idle();
    // zero sample rate: only start zero passes
    load_config(make_config(16'd0, 24'd0, 24'd40, nominal_slope(24'd40), 15'd8192,
                            32'd300000000, 25'd1));
    send_index(24'd0);
    send_index(24'd5);
    wait_idle();
    load_config(make_config(16'd0, 24'd1, 24'd40, nominal_slope(24'd40), 15'd8192,
                            32'd300000000, 25'd1));
    send_index(24'd5);
    wait_idle();
    // zero burst length
    load_config(make_config(16'd100, 24'd100, 24'd0, 32'hFFFF_FFFF, 15'h7FFF,
                            32'd300000000, 25'd50));
    send_index(24'd100);
    wait_idle();
    // largest sample_count marks the top index as last
    load_config(make_config(16'hFFFF, 24'hFF_FFFF, 24'hFF_FFFF, 32'hFFFF_FFFF, 15'h7FFF,
                            32'hFFFF_FFFF, 25'd16777216));
    send_index(24'hFF_FFFF);
    wait_idle();
  endtask

  task automatic test_random_configs();
    burst_cfg_t c;
    for (int k = 0; k < RANDOM_CONFIGS; k++) begin
      if (k == 0) c = make_config('1, '1, '1, '1, '1, '1, 25'd16777216);
      else if (k == 1) c = make_config('0, '0, '0, '0, '0, '0, '0);
      else c = random_config();
      load_config(c);
      tx_no_idle = ($urandom_range(0, 3) == 0);
      rx_no_idle = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < ITEMS_PER_CONFIG; i++) send_index(pick_index());
      wait_idle();
    end
    tx_no_idle = 1'b0;
    rx_no_idle = 1'b0;
  endtask

  task automatic test_output_hold_off();
    load_config(random_config());
    // receiver holds off while the sender keeps offering
    -> hold_off_start;
    tx_no_idle = 1'b1;
    for (int i = 0; i < 60; i++) send_index(pick_index());
    tx_no_idle = 1'b0;
    // sender pauses until the pipeline has drained
    wait_idle();
    for (int i = 0; i < 20; i++) send_index(pick_index());
    wait_idle();
  endtask

  // long receiver hold-off, counted here
  initial begin
    forever begin
      @(hold_off_start);
      rx_hold_off <= 1'b1;
      repeat (HOLD_OFF_CYCLES) @(posedge clk);
      rx_hold_off <= 1'b0;
    end
  end

  task automatic report_mismatch(input string what, input logic [23:0] idx,
                                 input int exp_v, input int act_v);
    mismatches++;
    if (reports < MAX_REPORTS) begin
      $display("%0t: %s mismatch at index %0d: expected %0d, actual %0d",
               $time, what, idx, exp_v, act_v);
    end
    reports++;
  endtask

  // output transactions: compare with the oldest expected sample
  initial begin
    int rx_wait;
    pending_sample_t exp_s;
    rx_wait = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_ready) begin
        results_checked++;
        if (expected_samples.size() == 0) begin
          report_mismatch("unexpected sample", 24'd0, 0, $signed(m_axis_tdata));
        end else begin
          exp_s = expected_samples.pop_front();
          if (m_axis_tdata !== exp_s.res.sample)
            report_mismatch("sample", exp_s.idx, exp_s.res.sample, $signed(m_axis_tdata));
          if (m_axis_tlast !== exp_s.res.last)
            report_mismatch("tlast", exp_s.idx, exp_s.res.last, m_axis_tlast);
          if (m_axis_tuser !== exp_s.res.start_invalid)
            report_mismatch("start_invalid", exp_s.idx, exp_s.res.start_invalid,
                            m_axis_tuser);
        end
        rx_wait = rx_no_idle ? 0 : $urandom_range(0, 11);
      end
      // next ready, one assignment per edge
      if (rx_hold_off) begin
        m_ready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        m_ready <= 1'b0;
      end else begin
        m_ready <= 1'b1;
      end
    end
  end

  // run limit
  initial begin
    #8000000;
    $display("CHECKS FAILED");
    $finish;
  end

  // test sequence
  initial begin
    for (int k = 0; k <= TAB_N; k++) sine_rom[k] = sine_mag_q16(k);
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_special_cases();
    test_random_configs();
    test_output_hold_off();
    repeat (LATENCY * 4) @(posedge clk);
    if (expected_samples.size() != 0) mismatches++;
    if (reports > MAX_REPORTS) $display("%0d further mismatch reports suppressed",
                                        reports - MAX_REPORTS);
    $display("run: %0d indices sent over %0d register settings, %0d samples checked",
             items_sent, configs_loaded, results_checked);
    $display("covered envelope corners, start checks, saturation and a %0d-cycle output stall",
             HOLD_OFF_CYCLES);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
